// ===== hdl/hbke_pkg.sv =====
// ----------------------------------------------------------------------------
// hbke_pkg
// Shared constants, types and mask helpers for the Hamming-ball key
// enumerator.
// ----------------------------------------------------------------------------
package hbke_pkg;

  localparam int KEY_BITS        = 32;
  localparam int MAX_FLIPS_LIMIT = 10;
  localparam int FLIP_W          = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;
  // shift amount for the next-combination block, up to KEY_BITS + 1
  localparam int SHIFT_W         = $clog2(KEY_BITS + 2);

  // largest usable flip count
  localparam int EFF_CAP = (MAX_FLIPS_LIMIT < KEY_BITS) ? MAX_FLIPS_LIMIT : KEY_BITS;

  localparam logic [KEY_BITS-1:0] BASE_KEY_RESET  = KEY_BITS'(32'h9E3DF386);
  localparam logic [FLIP_W-1:0]   MAX_FLIPS_RESET = FLIP_W'(10);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLIPS = 1'b1;

  // result of one next-combination step
  typedef struct packed {
    logic                has_next;
    logic [KEY_BITS-1:0] mask;
  } step_t;

  // top k bits set: first combination of weight k
  function automatic logic [KEY_BITS-1:0] first_mask(input logic [FLIP_W-1:0] k);
    logic [KEY_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      m[KEY_BITS-1-i] = (i < int'(k));
    end
    return m;
  endfunction

  // low k bits set: last combination of weight k
  function automatic logic [KEY_BITS-1:0] last_mask(input logic [FLIP_W-1:0] k);
    logic [KEY_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      m[i] = (i < int'(k));
    end
    return m;
  endfunction

endpackage

// ===== hdl/hbke_next_mask.sv =====
// ----------------------------------------------------------------------------
// hbke_next_mask
// Next same-weight flip mask in lexicographic order of string positions,
// where position 0 is the top key bit.
// ----------------------------------------------------------------------------
module hbke_next_mask
  import hbke_pkg::*;
(
  input  logic [KEY_BITS-1:0] mask,
  output step_t               step
);

  logic [KEY_BITS:0]   ext;
  logic [KEY_BITS:0]   inc;
  logic [KEY_BITS-1:0] tail;      // trailing ones of the mask
  logic [KEY_BITS:0]   tail_end;  // one-hot at the first zero above them
  logic [SHIFT_W-1:0]  tail_len;
  logic [SHIFT_W-1:0]  shamt;
  logic [KEY_BITS-1:0] rest;
  logic [KEY_BITS-1:0] low_bit;
  logic [KEY_BITS-1:0] block;

  // split off the packed run at the low end
  assign ext      = {1'b0, mask};
  assign inc      = ext + {{KEY_BITS{1'b0}}, 1'b1};
  assign tail     = mask & ~inc[KEY_BITS-1:0];
  assign tail_end = inc & ~ext;

  // one-hot to binary: length of the trailing run
  always_comb begin
    tail_len = '0;
    for (int j = 0; j <= KEY_BITS; j++) begin
      if (tail_end[j]) begin
        tail_len = tail_len | SHIFT_W'(j);
      end
    end
  end

  assign shamt = tail_len + SHIFT_W'(1);

  // lowest set bit outside the run moves down one place, run packs behind it
  assign rest    = mask & ~tail;
  assign low_bit = rest & (~rest + {{(KEY_BITS-1){1'b0}}, 1'b1});
  assign block   = low_bit - (low_bit >> shamt);

  assign step.has_next = |rest;
  assign step.mask     = (rest & ~low_bit) | block;

endmodule

// ===== hdl/hamming_ball_key_enumerator_top.sv =====
// ----------------------------------------------------------------------------
// hamming_ball_key_enumerator_top
// Steps through every key 1 to max_flips (clamped 1..10) flips from base_key.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready, restart): each word is one request.
//   restart = 1 begins again at the first one-bit candidate, restart = 0
//   asks for the next candidate in order of weight, then lexicographic
//   order of flipped positions (position 0 is key bit 31).
//   out channel (out_valid/out_ready): one result word per request with
//   candidate, flip_count, final_res and exhausted.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_addr
//   (0 base_key, 1 max_flips) at once; write only while idle.
// Timing:
//   one request per cycle sustained while out_ready stays high; a result is
//   valid in the cycle after its request is taken. A single combinational
//   next-combination block lies between the enumeration state and result register.
// Reset and stall:
//   rst clears the enumeration state and the result valid flag and loads
//   the default base key and flip limit. While the receiver stalls, the
//   result register holds and in_ready drops; a request is taken in the
//   same cycle the held result leaves.
// ----------------------------------------------------------------------------
module hamming_ball_key_enumerator_top
  import hbke_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_BITS-1:0]   candidate,
  output logic [FLIP_W-1:0]     flip_count,
  output logic                  final_res,
  output logic                  exhausted
);

  logic [KEY_BITS-1:0] base_key;
  logic [FLIP_W-1:0]   max_flips;
  logic [KEY_BITS-1:0] flip_mask;
  logic [KEY_BITS-1:0] flip_mask_next;
  logic [FLIP_W-1:0]   weight;
  logic [FLIP_W-1:0]   weight_next;
  logic                done;
  logic                done_next;
  logic                issue;
  logic [FLIP_W-1:0]   lim;
  logic                accept;
  step_t               step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_key  <= BASE_KEY_RESET;
      max_flips <= MAX_FLIPS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_BASE_KEY:  base_key  <= cfg_data[KEY_BITS-1:0];
        CFG_MAX_FLIPS: max_flips <= cfg_data[FLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective flip limit
  always_comb begin
    if (max_flips == '0) begin
      lim = FLIP_W'(1);
    end else if (max_flips > FLIP_W'(EFF_CAP)) begin
      lim = FLIP_W'(EFF_CAP);
    end else begin
      lim = max_flips;
    end
  end

  hbke_next_mask u_next (
    .mask (flip_mask),
    .step (step)
  );

  // enumeration step for one request
  always_comb begin
    flip_mask_next = flip_mask;
    weight_next    = weight;
    done_next      = done;
    issue          = 1'b0;
    if (restart || (!done && weight == '0)) begin
      weight_next    = FLIP_W'(1);
      flip_mask_next = first_mask(FLIP_W'(1));
      done_next      = 1'b0;
      issue          = 1'b1;
    end else if (!done) begin
      if (weight > lim) begin
        done_next = 1'b1;
      end else if (step.has_next) begin
        flip_mask_next = step.mask;
        issue          = 1'b1;
      end else if (weight < lim) begin
        weight_next    = weight + FLIP_W'(1);
        flip_mask_next = first_mask(weight + FLIP_W'(1));
        issue          = 1'b1;
      end else begin
        done_next = 1'b1;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // enumeration state
  always_ff @(posedge clk) begin
    if (rst) begin
      flip_mask <= '0;
      weight    <= '0;
      done      <= 1'b0;
    end else if (accept) begin
      flip_mask <= flip_mask_next;
      weight    <= weight_next;
      done      <= done_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      candidate  <= issue ? (base_key ^ flip_mask_next) : '0;
      flip_count <= issue ? weight_next : '0;
      final_res  <= issue && (weight_next == lim) &&
                    (flip_mask_next == last_mask(weight_next));
      exhausted  <= !issue;
    end
  end

  // exhausted words carry no candidate
  a_exhausted_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && exhausted) |-> (candidate == '0 && flip_count == '0 && !final_res))
    else $error("exhausted word carries candidate data");

  // live candidates always have a flip count
  a_live_weight: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !exhausted) |-> (flip_count != '0))
    else $error("candidate issued with zero flip count");

  // once finished, a plain request reports exhausted
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && !restart && done) |=> (out_valid && exhausted))
    else $error("request after finish did not report exhausted");

  // mask popcount tracks the weight
  a_mask_weight: assert property (@(posedge clk) disable iff (rst)
    (weight != '0) |-> ($countones(flip_mask) == int'(weight)))
    else $error("flip mask weight differs from weight register");

endmodule
